FILE: hw/rtl/bdlp_pkg.sv
package bdlp_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned ElapsedW   = 8;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned StatesW    = CodeW * NumButtons;
  localparam int unsigned InDataW    = ((NumButtons + ElapsedW + 7) / 8) * 8;
  localparam int unsigned OutDataW   = ((StatesW + 7) / 8) * 8;
  localparam int unsigned CfgIdxW    = 1;

  typedef logic [TimeW-1:0] time_t;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgBounceTime = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLongTime   = 1'd1;

  localparam time_t BounceTimeRst = 16'd20;
  localparam time_t LongTimeRst   = 16'd1000;

  // button state, one-hot
  typedef enum logic [7:0] {
    BtnUp          = 8'b0000_0001,
    BtnBounce      = 8'b0000_0010,
    BtnPressed     = 8'b0000_0100,
    BtnLong        = 8'b0000_1000,
    BtnPressEdge   = 8'b0001_0000,
    BtnReleaseEdge = 8'b0010_0000,
    BtnLongEdge    = 8'b0100_0000,
    BtnLongRelease = 8'b1000_0000
  } btn_state_e;

  // external state codes
  localparam logic [CodeW-1:0] CodeUp          = 3'd0;
  localparam logic [CodeW-1:0] CodeBounce      = 3'd1;
  localparam logic [CodeW-1:0] CodePressed     = 3'd2;
  localparam logic [CodeW-1:0] CodeLong        = 3'd3;
  localparam logic [CodeW-1:0] CodePressEdge   = 3'd4;
  localparam logic [CodeW-1:0] CodeReleaseEdge = 3'd5;
  localparam logic [CodeW-1:0] CodeLongEdge    = 3'd6;
  localparam logic [CodeW-1:0] CodeLongRelease = 3'd7;

  function automatic logic [CodeW-1:0] state_code(btn_state_e st);
    logic [CodeW-1:0] c;
    unique case (st)
      BtnUp:          c = CodeUp;
      BtnBounce:      c = CodeBounce;
      BtnPressed:     c = CodePressed;
      BtnLong:        c = CodeLong;
      BtnPressEdge:   c = CodePressEdge;
      BtnReleaseEdge: c = CodeReleaseEdge;
      BtnLongEdge:    c = CodeLongEdge;
      BtnLongRelease: c = CodeLongRelease;
      default:        c = CodeUp;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/button_debounce_long_press.sv
// Pipeline: an accepted item is written into the input register and moves on into the
//   result register once that slot is free or being drained.
// Throughput: one item per cycle while the sink keeps m_axis_tready high; set by the
//   per-button state update, a single step of each button's FSM between the two registers.
// Reset (rst_ni, async low): all buttons up, held times zero, both stages empty,
//   bounce time 20 ms and long-press time 1000 ms.
module button_debounce_long_press (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items: [2:0] raw_levels, [10:3] elapsed_ms, rest zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdlp_pkg::InDataW-1:0]    s_axis_tdata,
  // result items: [8:0] button_states, rest zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bdlp_pkg::OutDataW-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdlp_pkg::TimeW-1:0]      cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  bdlp_pkg::time_t bounce_time_q, long_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_time_q <= bdlp_pkg::BounceTimeRst;
      long_time_q   <= bdlp_pkg::LongTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdlp_pkg::CfgBounceTime: bounce_time_q <= cfg_wdata_i;
        bdlp_pkg::CfgLongTime:   long_time_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic                              in_vld_q;
  logic [bdlp_pkg::NumButtons-1:0]   levels_q;
  logic [bdlp_pkg::ElapsedW-1:0]     elapsed_q;
  logic                              in_acc;
  logic                              advance;  // stage-1 item moves into the result reg

  // result slot is free, or being drained this cycle
  assign advance       = in_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      levels_q  <= s_axis_tdata[bdlp_pkg::NumButtons-1:0];
      elapsed_q <= s_axis_tdata[bdlp_pkg::NumButtons +: bdlp_pkg::ElapsedW];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-button state machines, all stepped together
  // ---------------------------------------------------------------------------
  logic [bdlp_pkg::StatesW-1:0] states_d;

  for (genvar b = 0; b < bdlp_pkg::NumButtons; b++) begin : g_btn
    bdlp_button u_btn (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .step_i        (advance),
      .pressed_i     (!levels_q[b]),     // active-low pins
      .elapsed_i     (elapsed_q),
      .bounce_time_i (bounce_time_q),
      .long_time_i   (long_time_q),
      .code_d_o      (states_d[b*bdlp_pkg::CodeW +: bdlp_pkg::CodeW])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 2: result register
  // ---------------------------------------------------------------------------
  logic                         out_vld_q;
  logic [bdlp_pkg::StatesW-1:0] states_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) states_q <= states_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(bdlp_pkg::OutDataW - bdlp_pkg::StatesW){1'b0}}, states_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input side stalls only when both stages are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // an item moved out of stage 1 always shows up as a result next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced item lost");

  // an accepted item lands in the input register
  a_accept_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_vld_q)
    else $error("accepted item lost");

endmodule

FILE: hw/rtl/bdlp_button.sv
// One button: state register, held-time counter and next-state logic.
module bdlp_button (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,     // item is consumed this cycle
  input  logic                           pressed_i,
  input  logic [bdlp_pkg::ElapsedW-1:0]  elapsed_i,
  input  bdlp_pkg::time_t                bounce_time_i,
  input  bdlp_pkg::time_t                long_time_i,
  output logic [bdlp_pkg::CodeW-1:0]     code_d_o     // code after this step
);

  bdlp_pkg::btn_state_e state_q, state_d;
  bdlp_pkg::time_t      held_q, held_d, held_sum;
  logic [bdlp_pkg::TimeW:0] sum_raw;

  // saturating add
  assign sum_raw  = {1'b0, held_q} + {{(bdlp_pkg::TimeW + 1 - bdlp_pkg::ElapsedW){1'b0}}, elapsed_i};
  assign held_sum = sum_raw[bdlp_pkg::TimeW] ? {bdlp_pkg::TimeW{1'b1}}
                                             : sum_raw[bdlp_pkg::TimeW-1:0];

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    unique case (state_q)
      bdlp_pkg::BtnUp: begin
        if (pressed_i) begin
          state_d = bdlp_pkg::BtnBounce;
          held_d  = '0;
        end
      end
      bdlp_pkg::BtnBounce: begin
        if (pressed_i) begin
          held_d = held_sum;
          if (held_sum > bounce_time_i) begin
            state_d = bdlp_pkg::BtnPressEdge;
            held_d  = '0;
          end
        end else begin
          state_d = bdlp_pkg::BtnUp;
          held_d  = '0;
        end
      end
      bdlp_pkg::BtnPressed: begin
        if (pressed_i) begin
          held_d = held_sum;
          if (held_sum > long_time_i) begin
            state_d = bdlp_pkg::BtnLongEdge;
            held_d  = '0;
          end
        end else begin
          state_d = bdlp_pkg::BtnReleaseEdge;
          held_d  = '0;
        end
      end
      bdlp_pkg::BtnLong: begin
        if (!pressed_i) state_d = bdlp_pkg::BtnLongRelease;
      end
      bdlp_pkg::BtnPressEdge: begin
        if (pressed_i) begin
          state_d = bdlp_pkg::BtnPressed;
          held_d  = '0;
        end else begin
          state_d = bdlp_pkg::BtnUp;
        end
      end
      bdlp_pkg::BtnLongEdge: begin
        if (pressed_i) begin
          state_d = bdlp_pkg::BtnLong;
          held_d  = '0;
        end else begin
          state_d = bdlp_pkg::BtnUp;
        end
      end
      default: state_d = bdlp_pkg::BtnUp;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdlp_pkg::BtnUp;
      held_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  assign code_d_o = bdlp_pkg::state_code(state_d);

endmodule

FILE: tb/button_debounce_long_press_tb.sv
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT ports
  // ---------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [2:0] raw_levels, [10:3] elapsed_ms, rest zero
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [8:0] button_states, rest zero
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [TimeW-1:0]    cfg_wdata_i;

  button_debounce_long_press dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  // Shadow copy of the per-button FSMs and the two thresholds.
  logic [CodeW-1:0]   btn_code [NumButtons];
  time_t              btn_held [NumButtons];
  time_t              bounce_limit;
  time_t              long_limit;

  logic [StatesW-1:0] expected_states [$];
  int                 err_cnt;

  // Typed expectation for the item currently offered (directed rows only).
  bit                 offer_fixed;
  logic [StatesW-1:0] offer_states;

  // Handshake knobs shared between the stimulus and the sink.
  bit                 idle_en;
  bit                 hold_req;

  // Slowly changing "finger" level per button, so that presses last long
  // enough to reach press edge, long press and the saturated counter.
  logic [NumButtons-1:0] pin_hold = '1;

  // Directed stimulus table
  typedef enum logic {RowTick, RowCfg} row_kind_e;
  typedef struct packed {
    row_kind_e             kind;
    logic [NumButtons-1:0] levels;
    logic [ElapsedW-1:0]   elapsed;
    logic [CfgIdxW-1:0]    idx;
    time_t                 val;
    logic                  fixed;
    logic [StatesW-1:0]    states;
  } dir_row_t;
  dir_row_t dir_rows [$];

  // ---------------------------------------------------------------------------
  // Predictor: one scan tick of every button FSM, returns packed codes
  // ---------------------------------------------------------------------------
  function automatic logic [StatesW-1:0] advance_buttons(logic [NumButtons-1:0] levels,
                                                         logic [ElapsedW-1:0] elapsed);
    logic [StatesW-1:0] packed_codes;
    logic [CodeW-1:0]   st;
    time_t              t;
    logic [TimeW:0]     sum;
    bit                 pressed;
    packed_codes = '0;
    for (int b = 0; b < NumButtons; b++) begin
      pressed = (levels[b] == 1'b0);    // active low pins
      st      = btn_code[b];
      t       = btn_held[b];
      sum     = {1'b0, t} + {{(TimeW + 1 - ElapsedW){1'b0}}, elapsed};
      case (st)
        CodeUp: begin
          if (pressed) begin
            st = CodeBounce;
            t  = '0;
          end
        end
        CodeBounce: begin
          if (pressed) begin
            t = sum[TimeW] ? '1 : sum[TimeW-1:0];   // saturate at all ones
            if (t > bounce_limit) begin
              st = CodePressEdge;
              t  = '0;
            end
          end else begin
            st = CodeUp;
            t  = '0;
          end
        end
        CodePressed: begin
          if (pressed) begin
            t = sum[TimeW] ? '1 : sum[TimeW-1:0];
            if (t > long_limit) begin
              st = CodeLongEdge;
              t  = '0;
            end
          end else begin
            st = CodeReleaseEdge;
            t  = '0;
          end
        end
        CodeLong: begin
          if (!pressed) st = CodeLongRelease;   // held time is kept
        end
        CodePressEdge: begin
          if (pressed) begin
            st = CodePressed;
            t  = '0;
          end else begin
            st = CodeUp;
          end
        end
        CodeLongEdge: begin
          if (pressed) begin
            st = CodeLong;
            t  = '0;
          end else begin
            st = CodeUp;
          end
        end
        default: st = CodeUp;   // release edges fall back to up
      endcase
      btn_code[b] = st;
      btn_held[b] = t;
      packed_codes[b*CodeW +: CodeW] = st;
    end
    return packed_codes;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout: reports a fail and stops the run if it has not finished.
  initial begin
    #5ms;
    $display("button_debounce_long_press regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both streams at the falling edge, where every input is
  // stable; a handshake seen here completes at the next rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic [StatesW-1:0] pred;
    logic [StatesW-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = advance_buttons(s_axis_tdata[NumButtons-1:0],
                               s_axis_tdata[NumButtons +: ElapsedW]);
        expected_states.push_back(offer_fixed ? offer_states : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_states.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result item: tdata=%h", m_axis_tdata);
        end else begin
          want = expected_states.pop_front();
          if (m_axis_tdata !== {{(OutDataW-StatesW){1'b0}}, want}) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("button_states mismatch: expected %h got %h (tdata %h)",
                       want, m_axis_tdata[StatesW-1:0], m_axis_tdata);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: random stall bursts, plus one long hold-off on request that backs
  // the two pipeline stages up into the input.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever @(posedge clk_i) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    while (expected_states.size() != 0) @(posedge clk_i);
  endtask

  // Offer one scan tick and wait for it to be taken.
  task automatic send_tick(logic [NumButtons-1:0] levels, logic [ElapsedW-1:0] elapsed,
                           bit fixed, logic [StatesW-1:0] states);
    bit took;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    offer_fixed  = fixed;
    offer_states = states;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-NumButtons-ElapsedW){1'b0}}, elapsed, levels};
    do begin
      @(negedge clk_i);
      took = s_axis_tvalid && s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Register write, only with the block drained and the input quiet.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, time_t val);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);   // pipeline already empty, a little margin
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgBounceTime: bounce_limit = val;
      CfgLongTime:   long_limit   = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_tick(logic [NumButtons-1:0] levels, logic [ElapsedW-1:0] elapsed);
    dir_rows.push_back('{RowTick, levels, elapsed, '0, '0, 1'b0, '0});
  endtask

  task automatic add_checked(logic [NumButtons-1:0] levels, logic [ElapsedW-1:0] elapsed,
                             logic [StatesW-1:0] states);
    dir_rows.push_back('{RowTick, levels, elapsed, '0, '0, 1'b1, states});
  endtask

  task automatic add_cfg(logic [CfgIdxW-1:0] idx, time_t val);
    dir_rows.push_back('{RowCfg, '0, '0, idx, val, 1'b0, '0});
  endtask

  // Random ticks: mostly held or released fingers with random timing; when
  // noisy, single-tick glitches and fully random pin patterns on top.
  task automatic run_phase(int n, int flip_odds, int el_lo, int el_hi, bit noisy);
    logic [NumButtons-1:0] levels;
    logic [ElapsedW-1:0]   elapsed;
    for (int k = 0; k < n; k++) begin
      for (int b = 0; b < NumButtons; b++)
        if ($urandom_range(0, flip_odds - 1) == 0) pin_hold[b] = ~pin_hold[b];
      levels = pin_hold;
      if (noisy) begin
        if ($urandom_range(0, 15) == 0)
          levels[$urandom_range(0, NumButtons - 1)] ^= 1'b1;
        if ($urandom_range(0, 9) == 0)
          levels = NumButtons'($urandom);
      end
      case ($urandom_range(0, 9))
        0:       elapsed = '0;
        1:       elapsed = '1;
        2:       elapsed = ElapsedW'($urandom_range(0, 255));
        default: elapsed = ElapsedW'($urandom_range(el_lo, el_hi));
      endcase
      send_tick(levels, elapsed, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    err_cnt       = 0;
    offer_fixed   = 1'b0;
    offer_states  = '0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    bounce_limit  = BounceTimeRst;
    long_limit    = LongTimeRst;
    for (int b = 0; b < NumButtons; b++) begin
      btn_code[b] = CodeUp;
      btn_held[b] = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, reset thresholds (20 / 1000 ms) first.
    add_checked(3'b111, 8'd0,   {CodeUp, CodeUp, CodeUp});            // after reset
    add_checked(3'b000, 8'd255, {CodeBounce, CodeBounce, CodeBounce});
    add_checked(3'b000, 8'd255, {CodePressEdge, CodePressEdge, CodePressEdge});
    add_tick(3'b000, 8'd255);        // pressed
    add_tick(3'b000, 8'd255);
    add_tick(3'b000, 8'd255);
    add_tick(3'b000, 8'd255);
    add_tick(3'b000, 8'd255);        // 1020 ms, long-press edge
    add_tick(3'b000, 8'd0);          // long held
    add_tick(3'b111, 8'd0);          // long release
    add_tick(3'b111, 8'd0);
    add_tick(3'b110, 8'd0);          // button 0 bounce
    add_tick(3'b111, 8'd0);          // bounce lost, back up
    add_tick(3'b101, 8'd20);
    add_tick(3'b101, 8'd20);         // exactly at threshold, still bounce
    add_tick(3'b101, 8'd1);          // one past, press edge
    add_tick(3'b111, 8'd0);          // released on press edge
    add_tick(3'b011, 8'd100);
    add_tick(3'b011, 8'd100);
    add_tick(3'b011, 8'd0);          // pressed
    add_tick(3'b111, 8'd0);          // release edge
    add_tick(3'b111, 8'd0);
    // Zero thresholds: any nonzero time passes.
    add_cfg(CfgBounceTime, 16'd0);
    add_cfg(CfgLongTime,   16'd0);
    add_checked(3'b000, 8'd0, {CodeBounce, CodeBounce, CodeBounce});
    add_tick(3'b000, 8'd1);          // press edge
    add_tick(3'b000, 8'd0);          // pressed, time cleared
    add_tick(3'b000, 8'd1);          // long-press edge
    add_tick(3'b110, 8'd0);          // buttons 1 and 2 released on long-press edge

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg)
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      else
        send_tick(dir_rows[r].levels, dir_rows[r].elapsed, dir_rows[r].fixed,
                  dir_rows[r].states);
    end

    // Thresholds at all ones: counters saturate, press edge never fires.
    write_reg(CfgBounceTime, 16'hFFFF);
    write_reg(CfgLongTime,   16'hFFFF);
    run_phase(400, 400, 250, 255, 1'b0);

    // Zero thresholds with noise.
    write_reg(CfgBounceTime, 16'd0);
    write_reg(CfgLongTime,   16'd0);
    run_phase(250, 12, 0, 4, 1'b1);

    // Quick debounce, long press unreachable: pressed counter saturates.
    write_reg(CfgBounceTime, 16'd5);
    write_reg(CfgLongTime,   16'hFFFF);
    run_phase(300, 400, 250, 255, 1'b0);

    // Small random thresholds; the sink holds off for a long stretch here.
    write_reg(CfgBounceTime, 16'($urandom_range(0, 60)));
    write_reg(CfgLongTime,   16'($urandom_range(0, 600)));
    hold_req = 1'b1;
    run_phase(300, 25, 0, 40, 1'b1);

    // Near the top of the threshold range, then fully random values.
    write_reg(CfgBounceTime, 16'd65534);
    write_reg(CfgLongTime,   16'd65534);
    run_phase(80, 30, 0, 255, 1'b1);
    write_reg(CfgBounceTime, 16'($urandom));
    write_reg(CfgLongTime,   16'($urandom));
    run_phase(170, 20, 0, 255, 1'b1);

    // Last part at full rate on both sides.
    write_reg(CfgBounceTime, 16'($urandom_range(0, 30)));
    write_reg(CfgLongTime,   16'($urandom_range(0, 300)));
    idle_en = 1'b0;
    run_phase(250, 15, 0, 30, 1'b1);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0 && expected_states.size() == 0) begin
      $display("button_debounce_long_press regression: pass");
    end else begin
      $display("button_debounce_long_press regression: fail");
    end
    $finish;
  end

endmodule
